[rtl/boi_pkg.sv]
// Shared constants, codes and command and status bus types for the boundary offset interpolator.
package boi_pkg;

    // Storage and coordinate format.
    localparam int CW        = 24;
    localparam int MAX_PTS   = 64;
    localparam int AW        = $clog2(MAX_PTS);
    localparam int CNT_W     = AW + 1;

    // Segment length root: floor(sqrt((dy^2 + dl^2) * 2^32)).
    localparam int SQS_W     = 2 * CW + 2;
    localparam int ROOT_W    = CW + 17;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int HL_W      = (ROOT_W + 1) / 2;
    localparam int HH_W      = ROOT_W - HL_W;

    // Shared divider.
    localparam int DVD_W     = CW + ROOT_W;
    localparam int DVS_W     = CW + 16;
    localparam int DREM_W    = DVS_W + 1;
    localparam int ITER_W    = $clog2(DVD_W + 1);

    // Offset term is clamped where the final sum saturates anyway.
    localparam int TM_W      = CW + 4;

    // Result status codes.
    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_SAMPLE   = 3'd3;
    localparam logic [2:0] ST_REFUSED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NORMAL_OFFSET = 2'd0;
    localparam logic [1:0] CFG_FWD_TOL       = 2'd1;
    localparam logic [1:0] CFG_LAT_TOL       = 2'd2;

    // Datapath operations.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
    localparam logic [OP_W-1:0] OP_HOLD     = 5'd2;
    localparam logic [OP_W-1:0] OP_WR_HOLD  = 5'd3;
    localparam logic [OP_W-1:0] OP_WR_RD    = 5'd4;
    localparam logic [OP_W-1:0] OP_KEEP     = 5'd5;
    localparam logic [OP_W-1:0] OP_SET_LAST = 5'd6;
    localparam logic [OP_W-1:0] OP_QCAP     = 5'd7;
    localparam logic [OP_W-1:0] OP_CAP0     = 5'd8;
    localparam logic [OP_W-1:0] OP_CAP1     = 5'd9;
    localparam logic [OP_W-1:0] OP_DIFF     = 5'd10;
    localparam logic [OP_W-1:0] OP_MUL1     = 5'd11;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 5'd12;
    localparam logic [OP_W-1:0] OP_DIV1_END = 5'd13;
    localparam logic [OP_W-1:0] OP_SQA      = 5'd14;
    localparam logic [OP_W-1:0] OP_SQB      = 5'd15;
    localparam logic [OP_W-1:0] OP_SQSUM    = 5'd16;
    localparam logic [OP_W-1:0] OP_SQRT     = 5'd17;
    localparam logic [OP_W-1:0] OP_MH1      = 5'd18;
    localparam logic [OP_W-1:0] OP_MH2      = 5'd19;
    localparam logic [OP_W-1:0] OP_MH3      = 5'd20;
    localparam logic [OP_W-1:0] OP_TERM     = 5'd21;
    localparam logic [OP_W-1:0] OP_SUM      = 5'd22;
    localparam logic [OP_W-1:0] OP_OUT      = 5'd23;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [AW-1:0]   rd_addr;
        logic [AW-1:0]   wr_addr;
        logic            first;
        logic [2:0]      code;
    } t_cmd;

    typedef struct packed {
        logic sort_gt;
        logic mrg_close;
        logic mrg_conflict;
        logic q_out;
        logic walk_adv;
    } t_stat;

endpackage

[rtl/boi_ctrl.sv]
// Sequencing state machine for trace loading, normalization and queries.
module boi_ctrl
    import boi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_cmd,
    input  logic i_last_point,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SORT_RD   = 5'd1;
    localparam logic [4:0] S_SORT_HOLD = 5'd2;
    localparam logic [4:0] S_SORT_RDJ  = 5'd3;
    localparam logic [4:0] S_SORT_CMP  = 5'd4;
    localparam logic [4:0] S_MRG_RD    = 5'd5;
    localparam logic [4:0] S_MRG_CHK   = 5'd6;
    localparam logic [4:0] S_MRG_END   = 5'd7;
    localparam logic [4:0] S_Q_RANGE   = 5'd8;
    localparam logic [4:0] S_WALK_RD   = 5'd9;
    localparam logic [4:0] S_WALK_CHK  = 5'd10;
    localparam logic [4:0] S_SEG_RD0   = 5'd11;
    localparam logic [4:0] S_SEG_RD1   = 5'd12;
    localparam logic [4:0] S_SEG_CAP1  = 5'd13;
    localparam logic [4:0] S_DIFF      = 5'd14;
    localparam logic [4:0] S_MUL1      = 5'd15;
    localparam logic [4:0] S_DIV1      = 5'd16;
    localparam logic [4:0] S_DIV1_END  = 5'd17;
    localparam logic [4:0] S_SQA       = 5'd18;
    localparam logic [4:0] S_SQB       = 5'd19;
    localparam logic [4:0] S_SQSUM     = 5'd20;
    localparam logic [4:0] S_SQRT      = 5'd21;
    localparam logic [4:0] S_MH1       = 5'd22;
    localparam logic [4:0] S_MH2       = 5'd23;
    localparam logic [4:0] S_MH3       = 5'd24;
    localparam logic [4:0] S_DIV2      = 5'd25;
    localparam logic [4:0] S_TERM      = 5'd26;
    localparam logic [4:0] S_SUM       = 5'd27;
    localparam logic [4:0] S_DONE      = 5'd28;

    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_kept, n_kept;
    logic [AW-1:0]    r_s, n_s;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic             r_ready, n_ready;
    logic             r_stopped, n_stopped;
    logic [2:0]       r_code, n_code;
    logic             r_out_valid, n_out_valid;

    logic             accept;
    logic [CNT_W-1:0] eff_n;
    logic [CNT_W-1:0] s_inc;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign eff_n       = r_ready ? '0 : r_n;
    assign s_inc       = {1'b0, r_s} + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_kept      = r_kept;
        n_s         = r_s;
        n_iter      = r_iter;
        n_ready     = r_ready;
        n_stopped   = r_stopped;
        n_code      = r_code;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_cmd.code  = r_code;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_LOAD) begin
                        if (r_ready) begin
                            n_ready   = 1'b0;
                            n_stopped = 1'b0;
                            n_s       = '0;
                        end
                        if (eff_n < CNT_W'(MAX_PTS)) begin
                            o_cmd.op      = OP_LOAD;
                            o_cmd.wr_addr = eff_n[AW-1:0];
                            n_n           = eff_n + CNT_W'(1);
                            n_code        = ST_STORED;
                        end else begin
                            n_n    = eff_n;
                            n_code = ST_FULL;
                        end
                        if (i_last_point) begin
                            n_i     = CNT_W'(1);
                            n_state = S_SORT_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        if (!r_ready || r_stopped) begin
                            n_code  = ST_REFUSED;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.op = OP_QCAP;
                            n_state  = S_Q_RANGE;
                        end
                    end
                end
            end
            // Insertion sort: each comparison reads the neighbour in S_SORT_RDJ and compares in S_SORT_CMP.
            S_SORT_RD: begin
                if (r_i < r_n) begin
                    o_cmd.rd_addr = r_i[AW-1:0];
                    n_state       = S_SORT_HOLD;
                end else begin
                    n_i     = '0;
                    n_kept  = '0;
                    n_state = S_MRG_RD;
                end
            end
            S_SORT_HOLD: begin
                o_cmd.op = OP_HOLD;
                n_j      = r_i;
                n_state  = S_SORT_RDJ;
            end
            S_SORT_RDJ: begin
                if (r_j == '0) begin
                    o_cmd.op      = OP_WR_HOLD;
                    o_cmd.wr_addr = '0;
                    n_i           = r_i + CNT_W'(1);
                    n_state       = S_SORT_RD;
                end else begin
                    o_cmd.rd_addr = AW'(r_j - CNT_W'(1));
                    n_state       = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                o_cmd.wr_addr = r_j[AW-1:0];
                if (i_stat.sort_gt) begin
                    o_cmd.op = OP_WR_RD;
                    n_j      = r_j - CNT_W'(1);
                    n_state  = S_SORT_RDJ;
                end else begin
                    o_cmd.op = OP_WR_HOLD;
                    n_i      = r_i + CNT_W'(1);
                    n_state  = S_SORT_RD;
                end
            end
            // Merge pass: compacts the sorted trace in place.
            S_MRG_RD: begin
                if (r_i < r_n) begin
                    o_cmd.rd_addr = r_i[AW-1:0];
                    n_state       = S_MRG_CHK;
                end else begin
                    n_state = S_MRG_END;
                end
            end
            S_MRG_CHK: begin
                n_i     = r_i + CNT_W'(1);
                n_state = S_MRG_RD;
                if (r_kept != '0 && i_stat.mrg_close) begin
                    if (i_stat.mrg_conflict) begin
                        n_n     = '0;
                        n_code  = ST_REJECTED;
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.op      = OP_KEEP;
                    o_cmd.wr_addr = r_kept[AW-1:0];
                    o_cmd.first   = (r_kept == '0);
                    n_kept        = r_kept + CNT_W'(1);
                end
            end
            S_MRG_END: begin
                n_state = S_DONE;
                if (r_kept >= CNT_W'(2)) begin
                    o_cmd.op  = OP_SET_LAST;
                    n_ready   = 1'b1;
                    n_stopped = 1'b0;
                    n_s       = '0;
                    n_n       = r_kept;
                    n_code    = ST_READY;
                end else begin
                    n_n    = '0;
                    n_code = ST_REJECTED;
                end
            end
            S_Q_RANGE: begin
                if (i_stat.q_out) begin
                    n_stopped = 1'b1;
                    n_code    = ST_REFUSED;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            // Segment walk: the index only moves forward.
            S_WALK_RD: begin
                if (s_inc < r_n) begin
                    o_cmd.rd_addr = s_inc[AW-1:0];
                    n_state       = S_WALK_CHK;
                end else begin
                    n_s     = AW'(r_n - CNT_W'(2));
                    n_state = S_SEG_RD0;
                end
            end
            S_WALK_CHK: begin
                if (i_stat.walk_adv) begin
                    n_s     = s_inc[AW-1:0];
                    n_state = S_WALK_RD;
                end else begin
                    n_state = S_SEG_RD0;
                end
            end
            S_SEG_RD0: begin
                o_cmd.rd_addr = r_s;
                n_state       = S_SEG_RD1;
            end
            S_SEG_RD1: begin
                o_cmd.op      = OP_CAP0;
                o_cmd.rd_addr = s_inc[AW-1:0];
                n_state       = S_SEG_CAP1;
            end
            S_SEG_CAP1: begin
                o_cmd.op = OP_CAP1;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = OP_MUL1;
                n_iter   = '0;
                n_state  = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.op = OP_DIV_STEP;
                n_iter   = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(DVD_W - 1)) begin
                    n_state = S_DIV1_END;
                end
            end
            S_DIV1_END: begin
                o_cmd.op = OP_DIV1_END;
                n_state  = S_SQA;
            end
            S_SQA: begin
                o_cmd.op = OP_SQA;
                n_state  = S_SQB;
            end
            S_SQB: begin
                o_cmd.op = OP_SQB;
                n_state  = S_SQSUM;
            end
            S_SQSUM: begin
                o_cmd.op = OP_SQSUM;
                n_iter   = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_iter   = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(ROOT_W - 1)) begin
                    n_state = S_MH1;
                end
            end
            S_MH1: begin
                o_cmd.op = OP_MH1;
                n_state  = S_MH2;
            end
            S_MH2: begin
                o_cmd.op = OP_MH2;
                n_state  = S_MH3;
            end
            S_MH3: begin
                o_cmd.op = OP_MH3;
                n_iter   = '0;
                n_state  = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.op = OP_DIV_STEP;
                n_iter   = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(DVD_W - 1)) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                o_cmd.op = OP_TERM;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_code   = ST_SAMPLE;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_kept      <= '0;
            r_s         <= '0;
            r_iter      <= '0;
            r_ready     <= 1'b0;
            r_stopped   <= 1'b0;
            r_code      <= ST_STORED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_i         <= n_i;
            r_j         <= n_j;
            r_kept      <= n_kept;
            r_s         <= n_s;
            r_iter      <= n_iter;
            r_ready     <= n_ready;
            r_stopped   <= n_stopped;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/boi_dp.sv]
// Datapath: trace memories, configuration, divider, square root and result registers.
module boi_dp
    import boi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd_bus,
    output t_stat                o_stat,
    input  logic signed [CW-1:0] i_coord_forward,
    input  logic signed [CW-1:0] i_coord_lateral,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CW-1:0]        i_cfg_data,
    output logic [2:0]           o_status,
    output logic signed [CW-1:0] o_out_forward,
    output logic signed [CW-1:0] o_out_lateral
);

    logic signed [CW-1:0] mem_f [MAX_PTS];
    logic signed [CW-1:0] mem_l [MAX_PTS];

    logic signed [CW-1:0] r_rd_f, r_rd_l;
    logic signed [CW-1:0] r_hf, r_hl, r_kf, r_kl;
    logic signed [CW-1:0] r_first_f, r_last_f;
    logic signed [CW-1:0] r_nofs;
    logic [7:0]           r_ftol, r_ltol;
    logic signed [CW-1:0] r_q, r_f0, r_l0, r_f1, r_l1;
    logic [CW-1:0]        r_dy, r_num;
    logic [CW:0]          r_dlm;
    logic                 r_dl_neg;
    logic [DVD_W-1:0]     r_dvd;
    logic [DVS_W-1:0]     r_dvs;
    logic [DREM_W-1:0]    r_drem;
    logic signed [CW+1:0] r_edge;
    logic [2*CW-1:0]      r_sqa;
    logic [SQS_W-1:0]     r_sqb;
    logic [SQ_W-1:0]      r_sq;
    logic [SREM_W-1:0]    r_srem;
    logic [ROOT_W-1:0]    r_root;
    logic [CW+HL_W-1:0]   r_mp_lo;
    logic [CW+HH_W-1:0]   r_mp_hi;
    logic signed [TM_W:0] r_term;
    logic signed [CW-1:0] r_lat;
    logic [2:0]           r_status;
    logic signed [CW-1:0] r_out_f, r_out_l;

    logic                 mem_we;
    logic signed [CW-1:0] wr_f, wr_l;
    logic signed [CW:0]   d_mrg_f, d_mrg_l, d_dy, d_dl, d_num;
    logic [CW:0]          d_mrg_lm;
    logic signed [CW+1:0] ftol_s, lo_lim, hi_lim, walk_lim, q_s;
    logic [DREM_W-1:0]    drem_sh;
    logic                 dq_bit;
    logic                 round_up;
    logic [DVD_W:0]       q_round;
    logic [SREM_W-1:0]    srem_sh, s_trial;
    logic [CW-1:0]        nofs_m;
    logic [TM_W-1:0]      term_m;
    logic signed [CW+5:0] sum_w;

    // Memory write mux.
    always_comb begin
        mem_we = 1'b0;
        wr_f   = r_rd_f;
        wr_l   = r_rd_l;
        case (i_cmd_bus.op)
            OP_LOAD: begin
                mem_we = 1'b1;
                wr_f   = i_coord_forward;
                wr_l   = i_coord_lateral;
            end
            OP_WR_HOLD: begin
                mem_we = 1'b1;
                wr_f   = r_hf;
                wr_l   = r_hl;
            end
            OP_WR_RD, OP_KEEP: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_f[i_cmd_bus.wr_addr] <= wr_f;
            mem_l[i_cmd_bus.wr_addr] <= wr_l;
        end
        r_rd_f <= mem_f[i_cmd_bus.rd_addr];
        r_rd_l <= mem_l[i_cmd_bus.rd_addr];
    end

    // Status compares.
    assign ftol_s   = (CW+2)'(signed'({1'b0, r_ftol}));
    assign q_s      = (CW+2)'(r_q);
    assign lo_lim   = (CW+2)'(r_first_f) - ftol_s;
    assign hi_lim   = (CW+2)'(r_last_f) + ftol_s;
    assign walk_lim = (CW+2)'(r_rd_f) + ftol_s;
    assign d_mrg_f  = (CW+1)'(r_rd_f) - (CW+1)'(r_kf);
    assign d_mrg_l  = (CW+1)'(r_rd_l) - (CW+1)'(r_kl);
    assign d_mrg_lm = d_mrg_l[CW] ? (CW+1)'(-d_mrg_l) : (CW+1)'(d_mrg_l);

    always_comb begin
        o_stat.sort_gt      = (r_rd_f > r_hf);
        o_stat.mrg_close    = (d_mrg_f <= (CW+1)'(signed'({1'b0, r_ftol})));
        o_stat.mrg_conflict = (d_mrg_lm > (CW+1)'(r_ltol));
        o_stat.q_out        = (q_s < lo_lim) || (q_s > hi_lim);
        o_stat.walk_adv     = (q_s > walk_lim);
    end

    // Segment differences.
    assign d_dy  = (CW+1)'(r_f1) - (CW+1)'(r_f0);
    assign d_dl  = (CW+1)'(r_l1) - (CW+1)'(r_l0);
    assign d_num = (CW+1)'(r_q) - (CW+1)'(r_f0);

    // Restoring divider step and half-away rounding.
    assign drem_sh  = {r_drem[DREM_W-2:0], r_dvd[DVD_W-1]};
    assign dq_bit   = (drem_sh >= {1'b0, r_dvs});
    assign round_up = (r_drem >= ({1'b0, r_dvs} - r_drem));
    assign q_round  = {1'b0, r_dvd} + (DVD_W+1)'(round_up);

    // Square root step, two radicand bits per cycle.
    assign srem_sh = {r_srem[SREM_W-3:0], r_sq[SQ_W-1:SQ_W-2]};
    assign s_trial = {r_root, 2'b01};

    assign nofs_m = r_nofs[CW-1] ? CW'(-r_nofs) : CW'(r_nofs);
    assign term_m = (q_round > (DVD_W+1)'(1) << (CW+3)) ? TM_W'(1) << (CW+3) : TM_W'(q_round);
    assign sum_w  = (CW+6)'(r_edge) + (CW+6)'(r_term);

    always_ff @(posedge i_clk) begin
        case (i_cmd_bus.op)
            OP_HOLD: begin
                r_hf <= r_rd_f;
                r_hl <= r_rd_l;
            end
            OP_KEEP: begin
                r_kf <= r_rd_f;
                r_kl <= r_rd_l;
                if (i_cmd_bus.first) begin
                    r_first_f <= r_rd_f;
                end
            end
            OP_SET_LAST: begin
                r_last_f <= r_kf;
            end
            OP_QCAP: begin
                r_q <= i_coord_forward;
            end
            OP_CAP0: begin
                r_f0 <= r_rd_f;
                r_l0 <= r_rd_l;
            end
            OP_CAP1: begin
                r_f1 <= r_rd_f;
                r_l1 <= r_rd_l;
            end
            OP_DIFF: begin
                r_dy     <= CW'(d_dy);
                r_dl_neg <= d_dl[CW];
                r_dlm    <= d_dl[CW] ? (CW+1)'(-d_dl) : (CW+1)'(d_dl);
                if (d_num[CW]) begin
                    r_num <= '0;
                end else if (d_num > d_dy) begin
                    r_num <= CW'(d_dy);
                end else begin
                    r_num <= CW'(d_num);
                end
            end
            OP_MUL1: begin
                r_dvd  <= DVD_W'(r_num * r_dlm);
                r_dvs  <= DVS_W'(r_dy);
                r_drem <= '0;
            end
            OP_DIV_STEP: begin
                r_drem <= dq_bit ? drem_sh - {1'b0, r_dvs} : drem_sh;
                r_dvd  <= {r_dvd[DVD_W-2:0], dq_bit};
            end
            OP_DIV1_END: begin
                // The rounded part never exceeds the lateral step.
                if (r_dl_neg) begin
                    r_edge <= (CW+2)'(r_l0) - (CW+2)'(q_round[CW:0]);
                end else begin
                    r_edge <= (CW+2)'(r_l0) + (CW+2)'(q_round[CW:0]);
                end
            end
            OP_SQA: begin
                r_sqa <= r_dy * r_dy;
            end
            OP_SQB: begin
                r_sqb <= SQS_W'(r_dlm * r_dlm);
            end
            OP_SQSUM: begin
                r_sq   <= {SQS_W'(r_sqa) + r_sqb, 32'd0};
                r_srem <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_sq <= {r_sq[SQ_W-3:0], 2'b00};
                if (srem_sh >= s_trial) begin
                    r_srem <= srem_sh - s_trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_srem <= srem_sh;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            OP_MH1: begin
                r_mp_lo <= nofs_m * r_root[HL_W-1:0];
            end
            OP_MH2: begin
                r_mp_hi <= nofs_m * r_root[ROOT_W-1:HL_W];
            end
            OP_MH3: begin
                r_dvd  <= DVD_W'(r_mp_lo) + (DVD_W'(r_mp_hi) << HL_W);
                r_dvs  <= {r_dy, 16'd0};
                r_drem <= '0;
            end
            OP_TERM: begin
                r_term <= r_nofs[CW-1] ? -(TM_W+1)'(term_m) : (TM_W+1)'(term_m);
            end
            OP_SUM: begin
                if (sum_w > (CW+6)'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
                    r_lat <= {1'b0, {(CW-1){1'b1}}};
                end else if (sum_w < (CW+6)'(signed'({1'b1, {(CW-1){1'b0}}}))) begin
                    r_lat <= {1'b1, {(CW-1){1'b0}}};
                end else begin
                    r_lat <= CW'(sum_w);
                end
            end
            OP_OUT: begin
                r_status <= i_cmd_bus.code;
                if (i_cmd_bus.code == ST_SAMPLE) begin
                    r_out_f <= r_q;
                    r_out_l <= r_lat;
                end else begin
                    r_out_f <= '0;
                    r_out_l <= '0;
                end
            end
            default: begin
                r_hf <= r_hf;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nofs <= '0;
            r_ftol <= 8'd1;
            r_ltol <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NORMAL_OFFSET: r_nofs <= i_cfg_data;
                CFG_FWD_TOL:       r_ftol <= i_cfg_data[7:0];
                CFG_LAT_TOL:       r_ltol <= i_cfg_data[7:0];
                default:           r_ltol <= r_ltol;
            endcase
        end
    end

    assign o_status      = r_status;
    assign o_out_forward = r_out_f;
    assign o_out_lateral = r_out_l;

endmodule

[rtl/boundary_offset_interpolator_unit.sv]
// Top level of the boundary offset interpolator: controller plus datapath.
// A plain load word stores one point while there is room; the word that closes a trace also
// runs an insertion sort and a merge pass over the stored points. A query walks the segments,
// then runs two 65-step divisions and a 41-step square root on shared serial units.
// One word is in work at a time.
// Reset (synchronous, active low) empties the trace and restores the register defaults.
module boundary_offset_interpolator_unit
    import boi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input word channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic signed [CW-1:0] i_coord_forward,
    input  logic signed [CW-1:0] i_coord_lateral,
    input  logic                 i_last_point,
    // Result word channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic signed [CW-1:0] o_out_forward,
    output logic signed [CW-1:0] o_out_lateral,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CW-1:0]        i_cfg_data
);

    // The controller owns all sequencing: point count, loop indexes, the
    // segment index and the trace flags. The datapath owns the memories,
    // the arithmetic units and the result register, and reports compares.
    t_cmd  cmd_bus;
    t_stat stat_bus;

    boi_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_last_point (i_last_point),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_stat       (stat_bus),
        .o_cmd        (cmd_bus)
    );

    // The result register is separate from the work registers, so a new
    // word can be taken while the previous result still waits downstream.
    boi_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (cmd_bus),
        .o_stat          (stat_bus),
        .i_coord_forward (i_coord_forward),
        .i_coord_lateral (i_coord_lateral),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_status        (o_status),
        .o_out_forward   (o_out_forward),
        .o_out_lateral   (o_out_lateral)
    );

endmodule

[tb/tb_boundary_offset_interpolator_unit.sv]
// Self-checking testbench for the boundary offset interpolator: trace loading, sorting and queries.
`timescale 1ns / 100ps

module tb_boundary_offset_interpolator_unit;
    import boi_pkg::*;

    // The watchdog limit is the number of cycles with no accepted word on either channel.
    // The slowest single word closes a full trace, with its sort and merge pass. The long
    // receiver hold-off comes on top of that.
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLDOFF_CYCLES = 800;
    localparam int TAIL_CYCLES    = 600;
    localparam longint CMAX_L     = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint CMIN_L     = -(longint'(1) <<< (CW - 1));
    localparam longint TERM_SAT   = longint'(1) <<< 40;

    typedef struct {
        logic [2:0]           status;
        logic signed [CW-1:0] fwd;
        logic signed [CW-1:0] lat;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_cmd;
    logic signed [CW-1:0] i_coord_forward;
    logic signed [CW-1:0] i_coord_lateral;
    logic                 i_last_point;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_status;
    logic signed [CW-1:0] o_out_forward;
    logic signed [CW-1:0] o_out_lateral;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [CW-1:0]        i_cfg_data;

    boundary_offset_interpolator_unit DUT (.*);

    // Predictor state: its own copy of the trace store and of the registers.
    longint  trace_fwd [MAX_PTS];
    longint  trace_lat [MAX_PTS];
    int      stored_points;
    bit      have_trace;
    bit      queries_halted;
    int      walk_seg;
    longint  offset_reg;
    longint  ftol_reg;
    longint  ltol_reg;

    // Results still owed by the block, oldest first.
    t_result pending_results[$];

    int  mismatches;
    int  words_sent;
    int  samples_seen;
    int  refusals_seen;
    int  traces_ready;
    int  traces_rejected;
    int  full_seen;
    int  idle_cycles;
    bit  send_quiet;
    bit  recv_quiet;
    int  holdoff_requests;
    int  holdoff_served;
    int  holdoff_left;

    // The clock runs at a period of 8 ns.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // round(a*b/c) with halves rounded away from zero, saturated at cap.
    function automatic longint scaled_quotient(longint a, longint b, longint c, longint cap);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        prod = 128'(a) * 128'(b);
        quo  = prod / 128'(c);
        rem  = prod % 128'(c);
        if (rem >= 128'(c) - rem) begin
            quo = quo + 1;
        end
        if (quo > 128'(cap)) begin
            return cap;
        end
        return longint'(quo);
    endfunction

    // Floor of the square root, found one bit at a time from the top.
    function automatic longint floor_root(logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'(1) << b);
            if (c * c <= n) begin
                r = c;
            end
        end
        return longint'(r);
    endfunction

    // Stable sort by forward coordinate, then merge points that lie too close.
    // Returns 1 when the trace is usable.
    function automatic bit close_trace();
        longint f;
        longint l;
        longint dl;
        int     j;
        int     kept;
        kept = 0;
        for (int i = 1; i < stored_points; i++) begin
            f = trace_fwd[i];
            l = trace_lat[i];
            j = i;
            while (j > 0 && trace_fwd[j-1] > f) begin
                trace_fwd[j] = trace_fwd[j-1];
                trace_lat[j] = trace_lat[j-1];
                j--;
            end
            trace_fwd[j] = f;
            trace_lat[j] = l;
        end
        for (int i = 0; i < stored_points; i++) begin
            if (kept > 0 && trace_fwd[i] - trace_fwd[kept-1] <= ftol_reg) begin
                dl = trace_lat[i] - trace_lat[kept-1];
                if (dl < 0) dl = -dl;
                if (dl > ltol_reg) return 1'b0;
                continue;
            end
            trace_fwd[kept] = trace_fwd[i];
            trace_lat[kept] = trace_lat[i];
            kept++;
        end
        stored_points = kept;
        return kept >= 2;
    endfunction

    // Interpolated, offset lateral for one query; returns the status code.
    function automatic logic [2:0] sample_trace(longint q, output longint lat);
        longint f0, f1, l0, l1, dy, dl, num, part, base, term, sum, h;
        int     s;
        logic [127:0] sq;
        lat = 0;
        if (!have_trace || queries_halted) return ST_REFUSED;
        if (q < trace_fwd[0] - ftol_reg || q > trace_fwd[stored_points-1] + ftol_reg) begin
            queries_halted = 1'b1;
            return ST_REFUSED;
        end
        s = walk_seg;
        while (s + 1 < stored_points && q > trace_fwd[s+1] + ftol_reg) s++;
        if (s + 1 >= stored_points) s = stored_points - 2;
        walk_seg = s;
        f0 = trace_fwd[s];
        f1 = trace_fwd[s+1];
        l0 = trace_lat[s];
        l1 = trace_lat[s+1];
        dy = f1 - f0;
        dl = l1 - l0;
        num = q - f0;
        if (num < 0) num = 0;
        if (num > dy) num = dy;
        part = scaled_quotient(num, (dl < 0) ? -dl : dl, dy, TERM_SAT);
        base = (dl < 0) ? l0 - part : l0 + part;
        sq = (128'(dy * dy) + 128'(dl * dl)) << 32;
        h = floor_root(sq);
        term = scaled_quotient((offset_reg < 0) ? -offset_reg : offset_reg, h, dy <<< 16,
                               TERM_SAT);
        if (offset_reg < 0) term = -term;
        sum = base + term;
        if (sum > CMAX_L) sum = CMAX_L;
        if (sum < CMIN_L) sum = CMIN_L;
        lat = sum;
        return ST_SAMPLE;
    endfunction

    // Advances the predictor by one accepted word and queues the result it owes.
    task automatic predict_word(logic c, logic signed [CW-1:0] f, logic signed [CW-1:0] l,
                                logic lp);
        t_result r;
        longint  lat;
        r.fwd = '0;
        r.lat = '0;
        if (c == CMD_LOAD) begin
            if (have_trace) begin
                stored_points  = 0;
                have_trace     = 1'b0;
                queries_halted = 1'b0;
                walk_seg       = 0;
            end
            r.status = ST_STORED;
            if (stored_points < MAX_PTS) begin
                trace_fwd[stored_points] = longint'(f);
                trace_lat[stored_points] = longint'(l);
                stored_points++;
            end else begin
                r.status = ST_FULL;
            end
            if (lp) begin
                if (close_trace()) begin
                    have_trace     = 1'b1;
                    queries_halted = 1'b0;
                    walk_seg       = 0;
                    r.status       = ST_READY;
                end else begin
                    stored_points = 0;
                    have_trace    = 1'b0;
                    r.status      = ST_REJECTED;
                end
            end
        end else begin
            r.status = sample_trace(longint'(f), lat);
            if (r.status == ST_SAMPLE) begin
                r.fwd = f;
                r.lat = CW'(lat);
            end
        end
        pending_results = {pending_results, r};
    endtask

    // Offers one word, sometimes after a random gap unless the sender is quiet, and returns
    // once the block has taken it. Called at a rising edge.
    task automatic send_word(logic c, logic signed [CW-1:0] f, logic signed [CW-1:0] l,
                             logic lp);
        if (!send_quiet && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            i_cmd           <= 1'($urandom_range(1));
            i_coord_forward <= CW'($urandom);
            i_coord_lateral <= CW'($urandom);
            i_last_point    <= 1'($urandom_range(1));
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= c;
        i_coord_forward <= f;
        i_coord_lateral <= l;
        i_last_point    <= lp;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predict_word(c, f, l, lp);
        words_sent++;
    endtask

    task automatic load_point(longint f, longint l, bit lp);
        send_word(CMD_LOAD, CW'(f), CW'(l), lp);
    endtask

    task automatic query_at(longint q);
        send_word(CMD_QUERY, CW'(q), CW'($urandom), 1'($urandom_range(1)));
    endtask

    // Registers change only with the block idle and nothing owed.
    task automatic write_reg(logic [1:0] idx, longint value);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CW'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_NORMAL_OFFSET: offset_reg = longint'($signed(CW'(value)));
            CFG_FWD_TOL:       ftol_reg   = value & 8'hFF;
            CFG_LAT_TOL:       ltol_reg   = value & 8'hFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(longint off, longint ftol, longint ltol);
        write_reg(CFG_NORMAL_OFFSET, off);
        write_reg(CFG_FWD_TOL, ftol);
        write_reg(CFG_LAT_TOL, ltol);
    endtask

    // Receiver: random stalls, quiet stretches, and the long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall    <= 1'b0;
            holdoff_left   <= 0;
            holdoff_served <= 0;
        end else if (holdoff_requests != holdoff_served) begin
            holdoff_served <= holdoff_requests;
            holdoff_left   <= HOLDOFF_CYCLES;
            i_out_stall    <= 1'b1;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            i_out_stall  <= 1'b1;
        end else begin
            i_out_stall <= !recv_quiet && ($urandom_range(99) < 36);
        end
    end

    // Result checker: every accepted result word is matched against the oldest one owed.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected result word status=%0d fwd=%0d lat=%0d",
                             o_status, o_out_forward, o_out_lateral);
                end
            end else begin
                want = pending_results.pop_front();
                case (want.status)
                    ST_SAMPLE:   samples_seen++;
                    ST_REFUSED:  refusals_seen++;
                    ST_READY:    traces_ready++;
                    ST_REJECTED: traces_rejected++;
                    ST_FULL:     full_seen++;
                    default: ;
                endcase
                if (o_status !== want.status || o_out_forward !== want.fwd ||
                    o_out_lateral !== want.lat) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: result mismatch exp status=%0d fwd=%0d lat=%0d",
                                 want.status, want.fwd, want.lat);
                        $display("       got status=%0d fwd=%0d lat=%0d",
                                 o_status, o_out_forward, o_out_lateral);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired with %0d results owed", pending_results.size());
            $display("tb_boundary_offset_interpolator_unit NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Directed checks: refusals before any trace, sorting with a merge, queries at both
    // ends and past the end within tolerance, stop after an out-of-span query, lateral
    // conflicts, a one-point trace, coordinate extremes and a saturating offset.
    task automatic test_directed();
        query_at(0);
        load_point(300000, -5000, 0);
        load_point(-100000, 20000, 0);
        load_point(100000, 7000, 0);
        load_point(100001, 7001, 1);
        query_at(-100001);
        query_at(-100000);
        query_at(50000);
        query_at(250000);
        query_at(300001);
        query_at(400000);
        query_at(200000);
        load_point(5, 10, 0);
        load_point(6, 12, 1);
        load_point(777, 1, 1);
        load_point(CMIN_L, CMAX_L, 0);
        load_point(CMAX_L, CMIN_L, 1);
        query_at(CMIN_L);
        query_at(0);
        query_at(CMAX_L);
        set_regs(CMAX_L, 255, 0);
        load_point(0, CMAX_L - 10, 0);
        load_point(65536, CMAX_L, 1);
        query_at(30000);
        set_regs(CMIN_L, 0, 255);
        load_point(-65536, CMIN_L + 5, 0);
        load_point(0, CMIN_L, 1);
        query_at(-1);
    endtask

    // More points than the store holds, the last one closing the trace.
    task automatic test_full_store();
        set_regs(-1000, 1, 1);
        for (int i = 0; i < MAX_PTS + 2; i++) begin
            load_point((MAX_PTS - i) * 4000, i * 300, i == MAX_PTS + 1);
        end
        for (int i = 0; i < 6; i++) query_at(4000 + i * 40000);
        load_point(0, 0, 0);
        for (int i = 0; i < MAX_PTS + 1; i++) load_point(i * 5, 0, 0);
        load_point(1, 0, 1);
    endtask

    // One random trace with its point order shuffled, then a walk of queries.
    task automatic random_trace_and_walk(int npts, bit wild);
        longint fs[MAX_PTS];
        longint ls[MAX_PTS];
        longint base, spacing, lat, tmpf, tmpl, q, lo, hi;
        int     k, nq;
        base    = longint'($signed(CW'($urandom_range(0, 8388607)))) - 8388608 / 2;
        spacing = $urandom_range(1, 65536);
        lat     = longint'($signed(CW'($urandom)));
        for (int i = 0; i < npts; i++) begin
            if (wild) begin
                fs[i] = longint'($signed(CW'($urandom)));
                ls[i] = longint'($signed(CW'($urandom)));
            end else begin
                fs[i] = base + i * spacing + $urandom_range(0, 3);
                lat   = lat + $signed($urandom_range(0, 200000)) - 100000;
                if (lat > CMAX_L) lat = CMAX_L;
                if (lat < CMIN_L) lat = CMIN_L;
                ls[i] = lat;
            end
        end
        for (int i = npts - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmpf = fs[i]; fs[i] = fs[k]; fs[k] = tmpf;
            tmpl = ls[i]; ls[i] = ls[k]; ls[k] = tmpl;
        end
        for (int i = 0; i < npts; i++) load_point(fs[i], ls[i], i == npts - 1);
        if (!have_trace) begin
            query_at(longint'($signed(CW'($urandom))));
            return;
        end
        lo = trace_fwd[0] - ftol_reg;
        hi = trace_fwd[stored_points-1] + ftol_reg;
        nq = $urandom_range(3, 10);
        q  = lo;
        for (int i = 0; i < nq; i++) begin
            if ($urandom_range(99) < 8) begin
                q = ($urandom_range(1)) ? lo - $urandom_range(1, 1000) : hi + $urandom_range(1, 1000);
                if (q < CMIN_L) q = CMIN_L;
                if (q > CMAX_L) q = CMAX_L;
            end else begin
                q = q + $urandom_range(0, 2 * (hi - lo) / nq);
                if ($urandom_range(99) < 10) q = lo + $urandom_range(0, hi - lo);
                if (q > hi) q = hi;
            end
            query_at(q);
        end
    endtask

    // Random traces under a rotation of register settings, extremes included.
    task automatic test_random(int target);
        longint offsets[5] = '{0, CMAX_L, CMIN_L, 65536, -32768};
        longint ftols[4]   = '{0, 255, 1, 17};
        longint ltols[4]   = '{255, 0, 1, 40};
        int     phase;
        int     n;
        phase = 0;
        send_quiet = 1'b1;
        recv_quiet = 1'b1;
        while (words_sent < target) begin
            if (phase == 4) begin
                send_quiet = 1'b0;
                recv_quiet = 1'b0;
            end
            if (phase % 3 == 0) begin
                set_regs(($urandom_range(3) == 0) ? longint'($signed(CW'($urandom)))
                                                  : offsets[(phase / 3) % 5],
                         ftols[(phase / 3) % 4], ltols[(phase / 3 + 1) % 4]);
            end
            if ($urandom_range(99) < 5) n = $urandom_range(20, MAX_PTS);
            else n = $urandom_range(2, 8);
            random_trace_and_walk(n, $urandom_range(99) < 10);
            if ($urandom_range(99) < 10) query_at(longint'($signed(CW'($urandom))));
            phase++;
        end
    endtask

    // The receiver holds off while the sender keeps offering words.
    task automatic test_backpressure();
        set_regs(4096, 2, 2);
        holdoff_requests++;
        load_point(0, 0, 0);
        load_point(65536, 65536, 1);
        for (int i = 0; i < 12; i++) query_at(i * 5000);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_LOAD;
        i_coord_forward = '0;
        i_coord_lateral = '0;
        i_last_point    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_NORMAL_OFFSET;
        i_cfg_data      = '0;
        send_quiet      = 1'b0;
        recv_quiet      = 1'b0;
        holdoff_requests = 0;
        mismatches = 0;
        words_sent = 0;
        samples_seen = 0;
        refusals_seen = 0;
        traces_ready = 0;
        traces_rejected = 0;
        full_seen = 0;
        stored_points = 0;
        have_trace = 1'b0;
        queries_halted = 1'b0;
        walk_seg = 0;
        offset_reg = 0;
        ftol_reg = 1;
        ltol_reg = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_backpressure();
        test_random(450);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d words: %0d samples, %0d refusals, %0d traces ready,",
                 words_sent, samples_seen, refusals_seen, traces_ready);
        $display("%0d traces rejected, %0d full-store drops, %0d mismatches.",
                 traces_rejected, full_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_boundary_offset_interpolator_unit OK");
        end else begin
            $display("tb_boundary_offset_interpolator_unit NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/boi_pkg.sv
rtl/boi_ctrl.sv
rtl/boi_dp.sv
rtl/boundary_offset_interpolator_unit.sv
tb/tb_boundary_offset_interpolator_unit.sv
